/* rtl/core/brdws_pkg.sv */
package brdws_pkg;

	localparam int unsigned AddrW   = 32;
	localparam int unsigned RegionW = 4;
	localparam int unsigned ClocksW = 6;
	localparam int unsigned OffsetW = 10;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 8;

	typedef enum logic [RegionW-1:0] {
		REGION_UNMAPPED  = 4'd0,
		REGION_BIOS      = 4'd1,
		REGION_EWRAM     = 4'd2,
		REGION_IWRAM     = 4'd3,
		REGION_IO        = 4'd4,
		REGION_IO_MIRROR = 4'd5,
		REGION_OPEN_BUS  = 4'd6,
		REGION_PALETTE   = 4'd7,
		REGION_VIDEO     = 4'd8,
		REGION_OBJECT    = 4'd9,
		REGION_ROM       = 4'd10,
		REGION_CART_RAM  = 4'd11
	} region_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_WORK_RAM_WAIT  = 2'd0,
		CFG_FIRST_WAIT_SEL = 2'd1,
		CFG_SEQ_WAIT_SEL   = 2'd2
	} cfg_idx_t;

	localparam logic [3:0] WorkRamWaitRst = 4'd13;
	localparam logic [7:0] FirstWaitRst   = 8'd0;
	localparam logic [3:0] SeqWaitRst     = 4'd0;

	localparam logic [21:0] IoPage      = 22'h010000; // 0x0400_0000 >> 10
	localparam logic [15:0] MirrorLow   = 16'h0800;
	localparam logic [7:0]  IoTop       = 8'h04;

	typedef struct packed {
		logic [3:0] work_ram_wait;
		logic [7:0] first_wait_select;
		logic [3:0] sequential_wait_select;
	} cfg_t;

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic             wr;
		logic             word;
		logic             seq;
	} req_t;

	typedef struct packed {
		region_t            region;
		logic [ClocksW-1:0] clocks;
		logic [OffsetW-1:0] offset;
		logic               dropped;
	} res_t;

	// first access (N) cost per 2-bit code
	function automatic logic [3:0] first_clocks(input logic [1:0] code);
		logic [3:0] c;
		case (code)
			2'd0:    c = 4'd5;
			2'd1:    c = 4'd4;
			2'd2:    c = 4'd3;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

	// slow sequential (S) cost for ROM windows
	function automatic logic [3:0] seq_slow_clocks(input logic [1:0] win);
		logic [3:0] c;
		case (win)
			2'd0:    c = 4'd3;
			2'd1:    c = 4'd5;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/brdws_cfg_regs.sv */
module brdws_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brdws_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [brdws_pkg::CfgDatW-1:0]   cfg_data,
	output brdws_pkg::cfg_t                 cfg
);

	brdws_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.work_ram_wait          <= brdws_pkg::WorkRamWaitRst;
			cfg_q.first_wait_select      <= brdws_pkg::FirstWaitRst;
			cfg_q.sequential_wait_select <= brdws_pkg::SeqWaitRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				brdws_pkg::CFG_WORK_RAM_WAIT:  cfg_q.work_ram_wait <= cfg_data[3:0];
				brdws_pkg::CFG_FIRST_WAIT_SEL: cfg_q.first_wait_select <= cfg_data;
				brdws_pkg::CFG_SEQ_WAIT_SEL:   cfg_q.sequential_wait_select <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/brdws_decode.sv */
module brdws_decode (
	input  brdws_pkg::req_t req,
	input  brdws_pkg::cfg_t cfg,
	output brdws_pkg::res_t res
);

	logic [31:0] a;
	logic [1:0]  win;
	logic [3:0]  n_clk;
	logic [3:0]  s_clk;
	logic        seq_eff;
	logic [4:0]  cart_clk;
	logic [4:0]  wram_cost;

	assign a = req.addr;
	assign win = a[26:25];

	always_comb begin
		n_clk = brdws_pkg::first_clocks(cfg.first_wait_select[{win, 1'b0} +: 2]);
		if (win == 2'd3) begin
			s_clk = n_clk;
		end else if (cfg.sequential_wait_select[win]) begin
			s_clk = 4'd2;
		end else begin
			s_clk = brdws_pkg::seq_slow_clocks(win);
		end
		// hint ignored at a 128 KB page boundary
		seq_eff  = req.seq && (a[16:1] != 16'd0);
		cart_clk = {1'b0, (seq_eff ? s_clk : n_clk)} + (req.word ? {1'b0, s_clk} : 5'd0);
		wram_cost = 5'd16 - {1'b0, cfg.work_ram_wait};
	end

	always_comb begin
		res.region  = brdws_pkg::REGION_UNMAPPED;
		res.clocks  = 6'd1;
		res.offset  = '0;
		res.dropped = 1'b0;
		if (a[31:28] != 4'd0) begin
			res.region = brdws_pkg::REGION_UNMAPPED;
		end else if (a[27]) begin
			res.region = (a[27:25] == 3'b111) ? brdws_pkg::REGION_CART_RAM
				: brdws_pkg::REGION_ROM;
			res.clocks = {1'b0, cart_clk};
		end else begin
			case (a[26:24])
				3'd0, 3'd1: res.region = brdws_pkg::REGION_BIOS;
				3'd2: begin
					res.region = brdws_pkg::REGION_EWRAM;
					res.clocks = req.word ? {wram_cost, 1'b0} : {1'b0, wram_cost};
				end
				3'd3: res.region = brdws_pkg::REGION_IWRAM;
				3'd4: begin
					if (a[31:10] == brdws_pkg::IoPage) begin
						res.region = brdws_pkg::REGION_IO;
						res.offset = a[9:0];
					end else if (a[31:24] == brdws_pkg::IoTop
							&& a[15:0] == brdws_pkg::MirrorLow) begin
						res.region = brdws_pkg::REGION_IO_MIRROR;
						res.offset = a[9:0];
					end else begin
						res.region = brdws_pkg::REGION_OPEN_BUS;
					end
				end
				3'd5: begin
					res.region = brdws_pkg::REGION_PALETTE;
					res.clocks = req.word ? 6'd2 : 6'd1;
				end
				3'd6: begin
					res.region = brdws_pkg::REGION_VIDEO;
					res.clocks = req.word ? 6'd2 : 6'd1;
				end
				default: res.region = brdws_pkg::REGION_OBJECT;
			endcase
		end
		res.dropped = req.wr && (res.region == brdws_pkg::REGION_BIOS
			|| res.region == brdws_pkg::REGION_OPEN_BUS);
	end

endmodule

/* rtl/core/bus_region_decode_wait_states_top.sv */
// channel  | handshake            | transfer
// ---------+----------------------+---------------------------------------------
// access   | start, busy          | access_address, is_write, is_word, is_sequential
// result   | done (strobe)        | target_region, wait_clocks, register_offset,
//          |                      | write_dropped
// config   | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One access per cycle; done strobes after the input and result registers.
// Path: input register -> decode and cost logic -> result register.
// busy is never raised and cfg_ready is always high.
// arst_n clears valid flags and config registers to their defaults.
// The receiver cannot stall; no result is held back.
module bus_region_decode_wait_states_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [31:0]                     access_address,
	input  logic                            is_write,
	input  logic                            is_word,
	input  logic                            is_sequential,
	output logic                            done,
	output logic [3:0]                      target_region,
	output logic [5:0]                      wait_clocks,
	output logic [9:0]                      register_offset,
	output logic                            write_dropped,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brdws_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [brdws_pkg::CfgDatW-1:0]   cfg_data
);

	brdws_pkg::cfg_t cfg;
	brdws_pkg::req_t req_s1;
	brdws_pkg::res_t res_comb;
	brdws_pkg::res_t res_s2;
	logic            vld_s1;
	logic            vld_s2;

	assign busy = 1'b0;

	brdws_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1.addr <= access_address;
			req_s1.wr   <= is_write;
			req_s1.word <= is_word;
			req_s1.seq  <= is_sequential;
		end
		if (vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	brdws_decode u_decode (
		.req (req_s1),
		.cfg (cfg),
		.res (res_comb)
	);

	assign done            = vld_s2;
	assign target_region   = res_s2.region;
	assign wait_clocks     = res_s2.clocks;
	assign register_offset = res_s2.offset;
	assign write_dropped   = res_s2.dropped;

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without a matching start");

	a_drop_region: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_dropped) |-> (target_region == brdws_pkg::REGION_BIOS
			|| target_region == brdws_pkg::REGION_OPEN_BUS))
		else $error("dropped write outside bios or open bus");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (wait_clocks != 6'd0 && wait_clocks <= 6'd32))
		else $error("wait clocks out of range");

	a_offset_region: assert property (@(posedge clk) disable iff (!arst_n)
		(done && register_offset != 10'd0) |-> (target_region == brdws_pkg::REGION_IO
			|| target_region == brdws_pkg::REGION_IO_MIRROR))
		else $error("register offset outside io regions");
`endif

endmodule

/* dv/bus_region_decode_wait_states_top_tb.sv */
module bus_region_decode_wait_states_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RandPerSetting = 313;
	localparam int unsigned SettleCycles   = 4;
	localparam int unsigned StallLimit     = 1000;
	localparam logic [1:0]  CFG_IDX_SPARE  = 2'd3;

	localparam brdws_pkg::cfg_t WaitCfgAtReset = '{4'd13, 8'h00, 4'h0};
	localparam logic [3:0] FirstCost [4] = '{4'd5, 4'd4, 4'd3, 4'd9};
	localparam logic [3:0] SeqSlowCost [3] = '{4'd3, 4'd5, 4'd9};

	// wram, first, seq; high bits beyond the register widths are deliberate
	localparam logic [7:0] FixedSettings [4][3] = '{
		'{8'h00, 8'hFF, 8'h0F},
		'{8'h0F, 8'h00, 8'h00},
		'{8'hF5, 8'hE4, 8'hA5},
		'{8'h37, 8'h1B, 8'hFA}
	};

	typedef struct packed {
		brdws_pkg::req_t acc;
		logic            known;
		brdws_pkg::res_t want;
	} access_row_t;

	localparam int unsigned NumRows = 24;
	localparam access_row_t AccessRows [NumRows] = '{
		'{'{32'h0000_0000, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_BIOS, 6'd1, 10'd0, 1'b0}},
		'{'{32'h01FF_FFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
			'{brdws_pkg::REGION_BIOS, 6'd1, 10'd0, 1'b1}},
		'{'{32'h0200_0000, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_EWRAM, 6'd6, 10'd0, 1'b0}},
		'{'{32'h02FF_FFFE, 1'b1, 1'b0, 1'b1}, 1'b1,
			'{brdws_pkg::REGION_EWRAM, 6'd3, 10'd0, 1'b0}},
		'{'{32'h0300_0000, 1'b1, 1'b1, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_IWRAM, 6'd1, 10'd0, 1'b0}},
		'{'{32'h0400_0000, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_IO, 6'd1, 10'd0, 1'b0}},
		'{'{32'h0400_03FF, 1'b1, 1'b1, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_IO, 6'd1, 10'h3FF, 1'b0}},
		'{'{32'h0400_0800, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{brdws_pkg::REGION_IO_MIRROR, 6'd1, 10'd0, 1'b0}},
		'{'{32'h04AB_0800, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h0400_0400, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_OPEN_BUS, 6'd1, 10'd0, 1'b1}},
		'{'{32'h04FF_FFFF, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_OPEN_BUS, 6'd1, 10'd0, 1'b0}},
		'{'{32'h0500_0000, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_PALETTE, 6'd2, 10'd0, 1'b0}},
		'{'{32'h0601_7FFE, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h07FF_FFFC, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{32'h0800_0000, 1'b0, 1'b1, 1'b1}, 1'b1,
			'{brdws_pkg::REGION_ROM, 6'd8, 10'd0, 1'b0}},
		'{'{32'h0800_0002, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{32'h0A00_0004, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{32'h0C02_0000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{32'h0DFF_FFFE, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{32'h0E00_0000, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{32'h0FFF_FFFF, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{32'h0E00_0001, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{32'h1000_0000, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{brdws_pkg::REGION_UNMAPPED, 6'd1, 10'd0, 1'b0}},
		'{'{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}, 1'b1,
			'{brdws_pkg::REGION_UNMAPPED, 6'd1, 10'd0, 1'b0}}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] access_address;
	logic        is_write;
	logic        is_word;
	logic        is_sequential;
	logic        done;
	logic [3:0]  target_region;
	logic [5:0]  wait_clocks;
	logic [9:0]  register_offset;
	logic        write_dropped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	logic            cur_known;
	brdws_pkg::res_t cur_want;
	brdws_pkg::res_t head_want;
	brdws_pkg::cfg_t wait_cfg;
	brdws_pkg::res_t awaited_decodes [$];
	logic [15:0]     regions_seen;
	int unsigned     mismatches;
	int unsigned     accesses_sent;
	int unsigned     decodes_checked;
	int unsigned     cfg_writes;
	int unsigned     quiet_cycles;

	bus_region_decode_wait_states_top dut (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic brdws_pkg::res_t decode_access(brdws_pkg::cfg_t c, brdws_pkg::req_t r);
		brdws_pkg::res_t o;
		logic [1:0]      win;
		logic [3:0]      n_cost;
		logic [3:0]      s_cost;
		logic            seq_ok;
		logic [5:0]      k;

		o = '{brdws_pkg::REGION_UNMAPPED, 6'd1, 10'd0, 1'b0};
		if (r.addr[31:28] != 4'h0) begin
			o.region = brdws_pkg::REGION_UNMAPPED;
		end else if (r.addr[27]) begin
			o.region = (r.addr < 32'h0E00_0000) ? brdws_pkg::REGION_ROM
				: brdws_pkg::REGION_CART_RAM;
			win = r.addr[26:25];
			n_cost = FirstCost[c.first_wait_select[2*win +: 2]];
			if (win == 2'd3)
				s_cost = n_cost;
			else if (c.sequential_wait_select[win])
				s_cost = 4'd2;
			else
				s_cost = SeqSlowCost[win];
			// 128 KB page boundary breaks the sequential burst
			seq_ok = r.seq && (r.addr[16:1] != 16'h0);
			k = seq_ok ? 6'(s_cost) : 6'(n_cost);
			if (r.word)
				k = k + 6'(s_cost);
			o.clocks = k;
		end else begin
			case (r.addr[26:24])
				3'd0, 3'd1: o.region = brdws_pkg::REGION_BIOS;
				3'd2: begin
					o.region = brdws_pkg::REGION_EWRAM;
					o.clocks = (6'd16 - 6'(c.work_ram_wait)) << r.word;
				end
				3'd3: o.region = brdws_pkg::REGION_IWRAM;
				3'd4: begin
					if ((r.addr & 32'hFFFF_FC00) == 32'h0400_0000) begin
						o.region = brdws_pkg::REGION_IO;
						o.offset = r.addr[9:0];
					end else if ((r.addr & 32'hFF00_FFFF) == 32'h0400_0800) begin
						o.region = brdws_pkg::REGION_IO_MIRROR;
						o.offset = r.addr[9:0];
					end else begin
						o.region = brdws_pkg::REGION_OPEN_BUS;
					end
				end
				3'd5: begin
					o.region = brdws_pkg::REGION_PALETTE;
					o.clocks = r.word ? 6'd2 : 6'd1;
				end
				3'd6: begin
					o.region = brdws_pkg::REGION_VIDEO;
					o.clocks = r.word ? 6'd2 : 6'd1;
				end
				default: o.region = brdws_pkg::REGION_OBJECT;
			endcase
		end
		o.dropped = r.wr && (o.region == brdws_pkg::REGION_BIOS
			|| o.region == brdws_pkg::REGION_OPEN_BUS);
		return o;
	endfunction

	function automatic brdws_pkg::req_t rand_access();
		brdws_pkg::req_t r;
		logic [31:0]     a;

		a = $urandom;
		case ($urandom_range(0, 11))
			0, 1: ;
			2: a[31:27] = 5'b0;
			3: a = {22'h01_0000, a[9:0]};
			4: a = {8'h04, a[23:16], 16'h0800};
			5: a[31:24] = 8'h04;
			6, 7, 8: a[31:27] = 5'b00001;
			9: begin
				a[31:27] = 5'b00001;
				a[16:1] = 16'h0;
			end
			10: a = {8'h04, a[23:16], 4'h0, a[11:0]};
			default: a[31:28] = 4'($urandom_range(1, 15));
		endcase
		r.addr = a;
		r.wr   = 1'($urandom_range(0, 1));
		r.word = 1'($urandom_range(0, 1));
		r.seq  = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send_access(brdws_pkg::req_t r, logic known, brdws_pkg::res_t want);
		@(negedge clk);
		start          <= 1'b1;
		access_address <= r.addr;
		is_write       <= r.wr;
		is_word        <= r.word;
		is_sequential  <= r.seq;
		cur_known      <= known;
		cur_want       <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start          <= 1'b0;
			access_address <= $urandom;
			is_write       <= 1'($urandom_range(0, 1));
			is_word        <= 1'($urandom_range(0, 1));
			is_sequential  <= 1'($urandom_range(0, 1));
		end
	endtask

	task automatic drain_decodes();
		hold_off(1);
		while (awaited_decodes.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic random_bursts(int unsigned count);
		int unsigned left;
		int unsigned burst;

		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && left > 0) begin
				send_access(rand_access(), 1'b0, '0);
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 6));
		end
	endtask

	task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			wait_cfg = WaitCfgAtReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_index)
					brdws_pkg::CFG_WORK_RAM_WAIT:
						wait_cfg.work_ram_wait = cfg_data[3:0];
					brdws_pkg::CFG_FIRST_WAIT_SEL:
						wait_cfg.first_wait_select = cfg_data;
					brdws_pkg::CFG_SEQ_WAIT_SEL:
						wait_cfg.sequential_wait_select = cfg_data[3:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				accesses_sent++;
				if (cur_known)
					awaited_decodes.push_back(cur_want);
				else
					awaited_decodes.push_back(decode_access(wait_cfg,
						'{access_address, is_write, is_word, is_sequential}));
			end
			if (done) begin
				if (awaited_decodes.size() == 0) begin
					$error("result with nothing expected: region %0d, clocks %0d",
						target_region, wait_clocks);
					mismatches++;
				end else begin
					head_want = awaited_decodes.pop_front();
					match_field("target_region", 32'(head_want.region), 32'(target_region));
					match_field("wait_clocks", 32'(head_want.clocks), 32'(wait_clocks));
					match_field("register_offset", 32'(head_want.offset),
						32'(register_offset));
					match_field("write_dropped", 32'(head_want.dropped),
						32'(write_dropped));
					decodes_checked++;
					regions_seen[target_region] = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (++quiet_cycles >= StallLimit) begin
			$display("bus_region_decode_wait_states_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		logic [7:0] setting [3];

		arst_n         = 1'b0;
		start          = 1'b0;
		access_address = '0;
		is_write       = 1'b0;
		is_word        = 1'b0;
		is_sequential  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = brdws_pkg::CFG_WORK_RAM_WAIT;
		cfg_data       = '0;
		cur_known      = 1'b0;
		cur_want       = '0;
		regions_seen   = '0;
		mismatches     = 0;
		accesses_sent  = 0;
		decodes_checked = 0;
		cfg_writes     = 0;
		quiet_cycles   = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset wait settings in force
		for (int i = 0; i < NumRows; i++) begin
			send_access(AccessRows[i].acc, AccessRows[i].known, AccessRows[i].want);
			if ($urandom_range(0, 4) == 0)
				hold_off($urandom_range(1, 3));
		end
		drain_decodes();

		for (int p = 0; p < 6; p++) begin
			for (int k = 0; k < 3; k++)
				setting[k] = (p < 4) ? FixedSettings[p][k] : 8'($urandom);
			write_cfg(brdws_pkg::CFG_WORK_RAM_WAIT, setting[0]);
			write_cfg(brdws_pkg::CFG_FIRST_WAIT_SEL, setting[1]);
			// spare index must not disturb anything
			write_cfg(CFG_IDX_SPARE, 8'($urandom));
			write_cfg(brdws_pkg::CFG_SEQ_WAIT_SEL, setting[2]);
			@(negedge clk);
			cfg_valid <= 1'b0;
			random_bursts(RandPerSetting);
			drain_decodes();
		end

		$display("%0d accesses over 7 wait settings, %0d results checked, %0d config writes",
			accesses_sent, decodes_checked, cfg_writes);
		$display("%0d of 12 target regions seen", $countones(regions_seen));
		if (mismatches == 0 && awaited_decodes.size() == 0)
			$display("bus_region_decode_wait_states_top_tb: done, clean");
		else
			$display("bus_region_decode_wait_states_top_tb: done, errors");
		$finish;
	end

endmodule

/* files.f */
rtl/core/brdws_pkg.sv
rtl/core/brdws_cfg_regs.sv
rtl/core/brdws_decode.sv
rtl/core/bus_region_decode_wait_states_top.sv
dv/bus_region_decode_wait_states_top_tb.sv
